// ===== design/core_count_hotplug_policy_defines.svh =====
// assertion macros for the core count hotplug policy block
// used by the top level only, no other dependencies
`ifndef CORE_COUNT_HOTPLUG_POLICY_DEFINES_SVH
`define CORE_COUNT_HOTPLUG_POLICY_DEFINES_SVH
`ifndef SYNTHESIS
`define CHP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CHP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHP_ASSERT(lbl, clk, rst, prop, msg)
`define CHP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/chp_pkg.sv =====
// shared types and constants of the core count hotplug policy block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package chp_pkg;
   localparam int RING_DEPTH = 25;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(RING_DEPTH + 1);
   localparam int LF_W       = 17;
   localparam int TIME_W     = 10;
   localparam int TASK_W     = 8;
   localparam int PROD_W     = LF_W + TIME_W;
   localparam int LSUM_W     = PROD_W + $clog2(RING_DEPTH);
   localparam int TSUM_W     = TIME_W + $clog2(RING_DEPTH);
   localparam int QUOT_W     = LF_W;
   localparam int QSTEP_W    = $clog2(QUOT_W + 1);
   localparam int AVG_W      = QUOT_W + 4;
   localparam int MF_W       = 12;
   localparam int NUM_WIN    = 4;
   localparam int WIN_W      = $clog2(NUM_WIN);

   localparam int WINDOW_MS [NUM_WIN] = '{100, 150, 250, 300};
   localparam logic [WIN_W-1:0] WIN_100 = 2'd0;
   localparam logic [WIN_W-1:0] WIN_150 = 2'd1;
   localparam logic [WIN_W-1:0] WIN_250 = 2'd2;
   localparam logic [WIN_W-1:0] WIN_300 = 2'd3;

   localparam logic CSR_MAX_FREQ = 1'b0;
   localparam logic CSR_TIME_CAP = 1'b1;
   localparam logic [MF_W-1:0]   MAX_FREQ_RESET = 12'd1200;
   localparam logic [TIME_W-1:0] TIME_CAP_RESET = 10'd500;

   typedef struct packed {
      logic [LF_W-1:0]   lf_prod;
      logic [TIME_W-1:0] time_ms;
      logic [TASK_W-1:0] tasks;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DIV,
      ST_DECIDE
   } state_type;
endpackage
`default_nettype wire

// ===== design/chp_req_if.sv =====
// sample channel of the core count hotplug policy block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface chp_req_if;
   logic        valid;
   logic        ready;
   logic [6:0]  load_cpu0;
   logic [6:0]  load_cpu1;
   logic [6:0]  load_cpu2;
   logic [6:0]  load_cpu3;
   logic [7:0]  freq_10mhz;
   logic [15:0] elapsed_ms;
   logic [7:0]  running_tasks;
   logic [3:0]  online_mask;
   modport source (output valid, load_cpu0, load_cpu1, load_cpu2, load_cpu3, freq_10mhz,
                   elapsed_ms, running_tasks, online_mask, input ready);
   modport sink (input valid, load_cpu0, load_cpu1, load_cpu2, load_cpu3, freq_10mhz,
                 elapsed_ms, running_tasks, online_mask, output ready);
endinterface
`default_nettype wire

// ===== design/chp_rsp_if.sv =====
// decision channel of the core count hotplug policy block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface chp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] needed_online;
   logic       keep_awake;
   modport source (output valid, needed_online, keep_awake, input ready);
   modport sink (input valid, needed_online, keep_awake, output ready);
endinterface
`default_nettype wire

// ===== design/core_count_hotplug_policy.sv =====
// core count hotplug policy, top level
// depends on chp_pkg, chp_req_if, chp_rsp_if, chp_ring, chp_div and the defines header
//
// req_chan carries one sample per transaction: four core loads, the clock,
// the elapsed time, the runnable task count and the online mask. rsp_chan
// returns exactly one transaction per sample with the wanted core count and
// the keep-awake flag. csr_we writes max_freq_mhz (index 0) or time_cap_ms
// (index 1) from csr_wdata; write only while no sample is in flight.
// A result is built in order: the ring is walked backwards through its
// single read port and the read pipeline drained, then four divisions run
// in the shared divider, then one decision step. One sample is in flight
// at a time, so a new sample is not taken before the last one's decision
// step; req_chan.ready is high whenever the block is idle.
// The result sits in an output register, so the next sample is taken while
// a stalled result still waits; a stall longer than one sample's work holds
// the block in its decision step until rsp_chan.ready returns.
// Reset is synchronous and clears the ring valid bits, the write pointer and
// the control registers; no sweep is needed, the block is ready once reset is released.
`timescale 1ns / 1ps
`default_nettype none
`include "core_count_hotplug_policy_defines.svh"
module core_count_hotplug_policy
   import chp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   chp_req_if.sink        req_chan,
   chp_rsp_if.source      rsp_chan,
   input  wire logic      csr_we,
   input  wire logic      csr_index,
   input  wire logic [11:0] csr_wdata
);
   state_type state_ff, state_in;

   logic [MF_W-1:0]   max_freq_ff;
   logic [TIME_W-1:0] time_cap_ff;
   logic [PTR_W-1:0]  wp_ff, wp_in;

   logic [6:0]        load0_ff, min_load_ff;
   logic [2:0]        online_ff;

   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  issue_ff;
   logic              s1_vld_ff, s2_vld_ff;
   logic [CNT_W-1:0]  s1_idx_ff, s2_idx_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [TIME_W-1:0] t2_ff;
   logic [TASK_W-1:0] task2_ff;

   logic [LSUM_W-1:0] lsum_ff [NUM_WIN];
   logic [TSUM_W-1:0] tsum_ff [NUM_WIN];
   logic [TASK_W:0]   tsk2_ff;
   logic [TASK_W+1:0] tsk3_ff;

   logic [WIN_W-1:0]  div_idx_ff;
   logic              div_run_ff;
   logic [QUOT_W-1:0] avg_ff [NUM_WIN];

   logic              rsp_vld_ff;
   logic [2:0]        need_ff;
   logic              keep_ff;

   logic              accept, rd_en, walk_done, div_start, div_done, rsp_load;
   logic [QUOT_W-1:0] div_q;
   entry_type         wr_entry, rd_entry;
   logic [8:0]        load_sum;
   logic [2:0]        online_cnt, need;
   logic [6:0]        min_load;
   logic              keep;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign wp_in = (wp_ff == PTR_W'(RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;

   // sample entry and online statistics
   always_comb begin
      load_sum = 9'(req_chan.load_cpu0) + 9'(req_chan.load_cpu1)
               + 9'(req_chan.load_cpu2) + 9'(req_chan.load_cpu3);
      wr_entry.lf_prod = LF_W'(load_sum * 17'(req_chan.freq_10mhz));
      wr_entry.time_ms   = (req_chan.elapsed_ms > 16'(time_cap_ff))
                         ? time_cap_ff : req_chan.elapsed_ms[TIME_W-1:0];
      wr_entry.tasks     = req_chan.running_tasks;
      online_cnt = 3'(req_chan.online_mask[0]) + 3'(req_chan.online_mask[1])
                 + 3'(req_chan.online_mask[2]) + 3'(req_chan.online_mask[3]);
      min_load = 7'd100;
      if (req_chan.online_mask[0] && req_chan.load_cpu0 < min_load) begin
         min_load = req_chan.load_cpu0;
      end
      if (req_chan.online_mask[1] && req_chan.load_cpu1 < min_load) begin
         min_load = req_chan.load_cpu1;
      end
      if (req_chan.online_mask[2] && req_chan.load_cpu2 < min_load) begin
         min_load = req_chan.load_cpu2;
      end
      if (req_chan.online_mask[3] && req_chan.load_cpu3 < min_load) begin
         min_load = req_chan.load_cpu3;
      end
   end

   chp_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept),
      .wr_addr (wp_in),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_entry)
   );

   chp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lsum_ff[div_idx_ff]),
      .divisor  (tsum_ff[div_idx_ff]),
      .done     (div_done),
      .quotient (div_q)
   );

   // decision rules
   logic [AVG_W-1:0] a100, a150, a250, a300;
   logic [AVG_W-1:0] thr20, thr60, thr80, thr120, thr180, thr200;
   logic [15:0]      t2x50;
   logic [16:0]      t3x100;

   always_comb begin
      a100   = AVG_W'(avg_ff[WIN_100]) * AVG_W'(10);
      a150   = AVG_W'(avg_ff[WIN_150]) * AVG_W'(10);
      a250   = AVG_W'(avg_ff[WIN_250]) * AVG_W'(10);
      a300   = AVG_W'(avg_ff[WIN_300]) * AVG_W'(10);
      thr20  = AVG_W'(max_freq_ff) * AVG_W'(20);
      thr60  = AVG_W'(max_freq_ff) * AVG_W'(60);
      thr80  = AVG_W'(max_freq_ff) * AVG_W'(80);
      thr120 = AVG_W'(max_freq_ff) * AVG_W'(120);
      thr180 = AVG_W'(max_freq_ff) * AVG_W'(180);
      thr200 = AVG_W'(max_freq_ff) * AVG_W'(200);
      t2x50  = 16'(tsk2_ff) * 16'd50;
      t3x100 = 17'(tsk3_ff) * 17'd100;
      need   = online_ff;
      case (online_ff)
         3'd1: begin
            if (load0_ff >= 7'd80 && a100 > thr80 && t3x100 >= 17'(3 * 250)) begin
               need = online_ff + 1'b1;
            end else if (t3x100 >= 17'(3 * 500) && load0_ff >= 7'd99 && a100 > thr60) begin
               need = online_ff + 1'b1;
            end
         end
         3'd2: begin
            if (t2x50 < 16'd250 && load0_ff < 7'd100 && a300 < thr20) begin
               need = online_ff - 1'b1;
            end else if (min_load_ff > 7'd40 && a150 > thr120
                         && t3x100 >= 17'(3 * 350)) begin
               need = online_ff + 1'b1;
            end
         end
         3'd3: begin
            if (t2x50 < 16'd350 && a300 < thr120) begin
               need = online_ff - 1'b1;
            end else if (t2x50 > 16'd350 && a300 < thr60) begin
               need = online_ff - 1'b1;
            end else if (min_load_ff > 7'd40 && a250 > thr180
                         && t3x100 >= 17'(3 * 451)) begin
               need = online_ff + 1'b1;
            end
         end
         3'd4: begin
            if (t3x100 < 17'(3 * 451) && a300 < thr200) begin
               need = online_ff - 1'b1;
            end else if (t3x100 >= 17'(3 * 451) && a300 < thr80) begin
               need = online_ff - 1'b1;
            end
         end
         default: begin
            need = online_ff;
         end
      endcase
      keep = (online_ff >= 3'd2) && (need >= 3'd2);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      rd_en     = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      walk_done = (issue_ff == CNT_W'(RING_DEPTH)) && !s1_vld_ff && !s2_vld_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            rd_en = (issue_ff < CNT_W'(RING_DEPTH));
            if (walk_done) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            div_start = !div_run_ff;
            if (div_done && div_idx_ff == WIN_W'(NUM_WIN - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!rsp_vld_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_freq_ff <= MAX_FREQ_RESET;
         time_cap_ff <= TIME_CAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_FREQ: max_freq_ff <= csr_wdata[MF_W-1:0];
            CSR_TIME_CAP: time_cap_ff <= csr_wdata[TIME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff      <= '0;
         issue_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         div_idx_ff <= '0;
         div_run_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= rd_en;
         s2_vld_ff <= s1_vld_ff;
         if (accept) begin
            wp_ff      <= wp_in;
            issue_ff   <= '0;
            div_idx_ff <= '0;
            div_run_ff <= 1'b0;
         end else if (rd_en) begin
            issue_ff <= issue_ff + 1'b1;
         end
         if (div_start) begin
            div_run_ff <= 1'b1;
         end else if (div_done) begin
            div_run_ff <= 1'b0;
            div_idx_ff <= div_idx_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // walk pipeline and accumulators
   always_ff @(posedge clock) begin
      if (accept) begin
         load0_ff    <= req_chan.load_cpu0;
         min_load_ff <= min_load;
         online_ff   <= online_cnt;
         rd_ptr_ff   <= wp_in;
         tsk2_ff     <= '0;
         tsk3_ff     <= '0;
         for (int w = 0; w < NUM_WIN; w++) begin
            lsum_ff[w] <= '0;
            tsum_ff[w] <= '0;
         end
      end else begin
         if (rd_en) begin
            rd_ptr_ff <= (rd_ptr_ff == '0) ? PTR_W'(RING_DEPTH - 1) : rd_ptr_ff - 1'b1;
         end
         if (s2_vld_ff) begin
            for (int w = 0; w < NUM_WIN; w++) begin
               if (tsum_ff[w] < TSUM_W'(WINDOW_MS[w])) begin
                  lsum_ff[w] <= lsum_ff[w] + LSUM_W'(prod_ff);
                  tsum_ff[w] <= tsum_ff[w] + TSUM_W'(t2_ff);
               end
            end
            if (s2_idx_ff < CNT_W'(2)) begin
               tsk2_ff <= tsk2_ff + (TASK_W + 1)'(task2_ff);
            end
            if (s2_idx_ff < CNT_W'(3)) begin
               tsk3_ff <= tsk3_ff + (TASK_W + 2)'(task2_ff);
            end
         end
      end
      s1_idx_ff <= issue_ff;
      s2_idx_ff <= s1_idx_ff;
      prod_ff   <= PROD_W'(rd_entry.lf_prod) * PROD_W'(rd_entry.time_ms);
      t2_ff     <= rd_entry.time_ms;
      task2_ff  <= rd_entry.tasks;
      if (div_done) begin
         avg_ff[div_idx_ff] <= (tsum_ff[div_idx_ff] == '0) ? '0 : div_q;
      end
      if (rsp_load) begin
         need_ff <= need;
         keep_ff <= keep;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.needed_online = need_ff;
   assign rsp_chan.keep_awake    = keep_ff;

   `CHP_ASSERT(a_keep_needs_two, clock, reset, rsp_chan.valid |-> (!rsp_chan.keep_awake || rsp_chan.needed_online >= 3'd2), "keep_awake with fewer than two cores wanted")
   `CHP_ASSERT(a_need_range, clock, reset, rsp_chan.valid |-> rsp_chan.needed_online <= 3'd4, "needed_online out of range")
   `CHP_ASSERT(a_accept_starts_walk, clock, reset, (req_chan.valid && req_chan.ready) |=> (state_ff == ST_WALK && issue_ff == '0), "walk did not start after a transaction")
   `CHP_ASSERT(a_div_idle_on_start, clock, reset, div_start |-> !div_run_ff && state_ff == ST_DIV, "divider started while busy")
endmodule
`default_nettype wire

// ===== design/chp_ring.sv =====
// sample ring memory, one write and one registered read port
// depends on chp_pkg; unwritten entries read as zero
`timescale 1ns / 1ps
`default_nettype none
module chp_ring
   import chp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [PTR_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   input  wire logic             rd_en,
   input  wire logic [PTR_W-1:0] rd_addr,
   output entry_type             rd_data
);
   entry_type             mem [RING_DEPTH];
   logic [RING_DEPTH-1:0] vld_ff;
   entry_type             data_ff;
   logic                  hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;
endmodule
`default_nettype wire

// ===== design/chp_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on chp_pkg; quotient must fit in QUOT_W bits
`timescale 1ns / 1ps
`default_nettype none
module chp_div
   import chp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [LSUM_W-1:0] dividend,
   input  wire logic [TSUM_W-1:0] divisor,
   output logic                   done,
   output logic [QUOT_W-1:0]      quotient
);
   logic [TSUM_W-1:0]  rem_ff, rem_in;
   logic [QUOT_W-1:0]  dvd_ff, dvd_in;
   logic [TSUM_W-1:0]  dsr_ff;
   logic [QSTEP_W-1:0] step_ff;
   logic               busy_ff, done_ff;
   logic [TSUM_W:0]    trial;
   logic               ge;

   always_comb begin
      trial  = {rem_ff, dvd_ff[QUOT_W-1]};
      ge     = trial >= {1'b0, dsr_ff};
      rem_in = ge ? TSUM_W'(trial - {1'b0, dsr_ff}) : trial[TSUM_W-1:0];
      dvd_in = {dvd_ff[QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[LSUM_W-1:QUOT_W];
         dvd_ff <= dividend[QUOT_W-1:0];
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dvd_ff <= dvd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == QSTEP_W'(QUOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the core count hotplug policy block: random and directed samples
// with a cycle-free decision predictor; depends on the top level, chp_pkg, chp_req_if and chp_rsp_if
`timescale 1ns / 1ps
module tb;
   import chp_pkg::*;

   typedef struct {
      logic [6:0]  load [4];
      logic [7:0]  freq;
      logic [15:0] ms;
      logic [7:0]  tasks;
      logic [3:0]  mask;
   } sample_t;

   typedef struct {
      logic [2:0] need;
      logic       awake;
   } decision_t;

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic csr_index = CSR_MAX_FREQ;
   logic [11:0] csr_wdata = '0;

   chp_req_if req_chan ();
   chp_rsp_if rsp_chan ();

   core_count_hotplug_policy uut (
      .clock(clock), .reset(reset), .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // model state
   logic [LF_W-1:0]   lf_ring [RING_DEPTH];
   logic [TIME_W-1:0] ms_ring [RING_DEPTH];
   logic [TASK_W-1:0] task_ring [RING_DEPTH];
   int unsigned       wr_ptr;
   logic [MF_W-1:0]   max_freq;
   logic [TIME_W-1:0] time_cap;

   sample_t   pending_samples [$];
   decision_t expected_decisions [$];
   int        errors = 0;
   int        quiet_cycles = 0;
   bit        no_idle = 0;
   bit        req_taken = 0;

   function automatic longint lf_average(int unsigned window);
      int unsigned p, count;
      longint tsum, lsum;
      p = wr_ptr; count = 0; tsum = 0; lsum = 0;
      while (tsum < window && count < RING_DEPTH) begin
         tsum += ms_ring[p];
         p = (p + RING_DEPTH - 1) % RING_DEPTH;
         count++;
      end
      p = wr_ptr; tsum = 0;
      for (int i = 0; i < count; i++) begin
         lsum += longint'(lf_ring[p]) * ms_ring[p];
         tsum += ms_ring[p];
         p = (p + RING_DEPTH - 1) % RING_DEPTH;
      end
      if (tsum == 0) return 0;
      return (lsum / tsum) * 10;
   endfunction

   function automatic longint task_average(int unsigned n);
      int unsigned p;
      longint sum;
      p = wr_ptr; sum = 0;
      for (int i = 0; i < n; i++) begin
         sum += task_ring[p];
         p = (p + RING_DEPTH - 1) % RING_DEPTH;
      end
      return (sum * 100) / n;
   endfunction

   function automatic decision_t decide_cores(sample_t s);
      decision_t d;
      int online, need, min_load, l0;
      longint mf;
      online = 0; min_load = 100; mf = max_freq; l0 = s.load[0];
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      lf_ring[wr_ptr] = LF_W'((int'(s.load[0]) + int'(s.load[1]) + int'(s.load[2])
                              + int'(s.load[3])) * int'(s.freq));
      ms_ring[wr_ptr] = (s.ms > time_cap) ? time_cap : TIME_W'(s.ms);
      task_ring[wr_ptr] = s.tasks;
      for (int i = 0; i < 4; i++)
         if (s.mask[i]) begin
            online++;
            if (s.load[i] < min_load) min_load = s.load[i];
         end
      need = online;
      case (online)
         1: begin
            if (l0 >= 80 && lf_average(100) > mf * 80 && task_average(3) >= 250) need++;
            else if (task_average(3) >= 500 && l0 >= 99 && lf_average(100) > mf * 60) need++;
         end
         2: begin
            if (task_average(2) < 250 && l0 < 100 && lf_average(300) < mf * 20) need--;
            else if (min_load > 40 && lf_average(150) > mf * 120 && task_average(3) >= 350)
               need++;
         end
         3: begin
            if (task_average(2) < 350 && lf_average(300) < mf * 120) need--;
            else if (task_average(2) > 350 && lf_average(300) < mf * 60) need--;
            else if (min_load > 40 && lf_average(250) > mf * 180 && task_average(3) > 450)
               need++;
         end
         4: begin
            if (task_average(3) <= 450 && lf_average(300) < mf * 200) need--;
            else if (task_average(3) > 450 && lf_average(300) < mf * 80) need--;
         end
         default: ;
      endcase
      d.need = 3'(need);
      d.awake = (online >= 2 && need >= 2);
      return d;
   endfunction

   function automatic sample_t random_sample();
      sample_t s;
      bit busy;
      busy = ($urandom_range(99) < 60);
      for (int i = 0; i < 4; i++)
         case ($urandom_range(9))
            0: s.load[i] = 7'($urandom_range(127));
            1, 2: s.load[i] = 7'($urandom_range(100));
            default: s.load[i] = busy ? 7'($urandom_range(100, 60)) : 7'($urandom_range(50));
         endcase
      s.freq = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(255, 20));
      case ($urandom_range(9))
         0: s.ms = 16'($urandom);
         1: s.ms = 16'($urandom_range(3));
         default: s.ms = 16'($urandom_range(200, 10));
      endcase
      s.tasks = ($urandom_range(9) == 0) ? 8'($urandom) :
                (busy ? 8'($urandom_range(8, 2)) : 8'($urandom_range(4)));
      s.mask = 4'($urandom);
      return s;
   endfunction

   function automatic sample_t make_sample(int l, int f, int m, int t, int mask);
      sample_t s;
      for (int i = 0; i < 4; i++) s.load[i] = 7'(l);
      s.freq = 8'(f); s.ms = 16'(m); s.tasks = 8'(t); s.mask = 4'(mask);
      return s;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic write_csr(logic idx, logic [11:0] value);
      @(negedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= value;
      @(negedge clock);
      csr_we <= 0;
      if (idx == CSR_MAX_FREQ) max_freq = value;
      else time_cap = value[TIME_W-1:0];
   endtask

   task automatic wait_drained();
      while (pending_samples.size() != 0 || expected_decisions.size() != 0 || req_chan.valid)
         @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 0;
      end else if (!req_chan.valid || req_taken) begin
         if (pending_samples.size() != 0 && (no_idle || $urandom_range(99) >= 36)) begin
            sample_t s;
            s = pending_samples.pop_front();
            req_chan.valid <= 1;
            req_chan.load_cpu0 <= s.load[0];
            req_chan.load_cpu1 <= s.load[1];
            req_chan.load_cpu2 <= s.load[2];
            req_chan.load_cpu3 <= s.load[3];
            req_chan.freq_10mhz <= s.freq;
            req_chan.elapsed_ms <= s.ms;
            req_chan.running_tasks <= s.tasks;
            req_chan.online_mask <= s.mask;
         end else begin
            req_chan.valid <= 0;
         end
      end
      rsp_chan.ready <= !reset && (no_idle || $urandom_range(99) >= 36);
      req_taken <= 0;
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            sample_t s;
            s.load[0] = req_chan.load_cpu0; s.load[1] = req_chan.load_cpu1;
            s.load[2] = req_chan.load_cpu2; s.load[3] = req_chan.load_cpu3;
            s.freq = req_chan.freq_10mhz; s.ms = req_chan.elapsed_ms;
            s.tasks = req_chan.running_tasks; s.mask = req_chan.online_mask;
            expected_decisions.push_back(decide_cores(s));
            req_taken <= 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_decisions.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               decision_t d;
               d = expected_decisions.pop_front();
               if (rsp_chan.needed_online !== d.need)
                  report_mismatch("needed_online", rsp_chan.needed_online, d.need);
               if (rsp_chan.keep_awake !== d.awake)
                  report_mismatch("keep_awake", rsp_chan.keep_awake, d.awake);
            end
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= 5000) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      logic [11:0] freq_set [6];
      logic [9:0]  cap_set [6];
      req_chan.valid = 0;
      req_chan.load_cpu0 = 0; req_chan.load_cpu1 = 0;
      req_chan.load_cpu2 = 0; req_chan.load_cpu3 = 0;
      req_chan.freq_10mhz = 0; req_chan.elapsed_ms = 0;
      req_chan.running_tasks = 0; req_chan.online_mask = 0;
      rsp_chan.ready = 0;
      for (int i = 0; i < RING_DEPTH; i++) begin
         lf_ring[i] = 0; ms_ring[i] = 0; task_ring[i] = 0;
      end
      wr_ptr = 0; max_freq = MAX_FREQ_RESET; time_cap = TIME_CAP_RESET;
      repeat (5) @(posedge clock);
      reset <= 0;

      // directed samples under reset settings
      pending_samples.push_back(make_sample(0, 0, 0, 0, 4'h0));
      pending_samples.push_back(make_sample(127, 255, 65535, 255, 4'hF));
      pending_samples.push_back(make_sample(100, 120, 100, 3, 4'h1));
      pending_samples.push_back(make_sample(100, 120, 100, 3, 4'h1));
      pending_samples.push_back(make_sample(99, 120, 120, 6, 4'h2));
      pending_samples.push_back(make_sample(100, 255, 150, 5, 4'h3));
      pending_samples.push_back(make_sample(100, 255, 150, 5, 4'h3));
      pending_samples.push_back(make_sample(10, 20, 300, 1, 4'h5));
      pending_samples.push_back(make_sample(90, 255, 250, 6, 4'h7));
      pending_samples.push_back(make_sample(90, 255, 250, 6, 4'hE));
      pending_samples.push_back(make_sample(30, 100, 300, 2, 4'hB));
      pending_samples.push_back(make_sample(20, 50, 300, 8, 4'hF));
      pending_samples.push_back(make_sample(100, 200, 300, 2, 4'hF));
      pending_samples.push_back(make_sample(127, 200, 80, 9, 4'h8));
      pending_samples.push_back(make_sample(45, 255, 501, 6, 4'h6));
      pending_samples.push_back(make_sample(0, 255, 1, 0, 4'hD));
      begin
         sample_t s;
         s = make_sample(100, 255, 100, 6, 4'hA);
         s.load[1] = 127; s.load[3] = 41;
         pending_samples.push_back(s);
      end
      wait_drained();

      freq_set = '{12'd1, 12'd4095, 12'd0, 12'd1200, 12'd300, 12'($urandom_range(4095, 1))};
      cap_set  = '{10'd1023, 10'd1, 10'd0, 10'd500, 10'd150, 10'($urandom_range(1023, 1))};
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_MAX_FREQ, freq_set[ph]);
         write_csr(CSR_TIME_CAP, {2'b00, cap_set[ph]});
         no_idle = (ph == 3);
         for (int i = 0; i < 105; i++) pending_samples.push_back(random_sample());
         wait_drained();
      end

      repeat (200) @(posedge clock);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end
endmodule
